// File: hw/rtl/hcb_pkg.sv
// shared widths, command and status types for the huffman code builder
`default_nettype none
package hcb_pkg;
	localparam int SYM_W       = 7;
	localparam int IN_WEIGHT_W = 16;
	localparam int WEIGHT_W    = 22;
	localparam int CODE_W      = 63;
	localparam int LEN_W       = 6;
	localparam logic [LEN_W-1:0] LEN_MAX = 6'd63;

	typedef struct packed {
		logic load;
		logic start;
		logic scan_rd;
		logic scan_cmp;
		logic tail_rd;
		logic swap_wr1;
		logic swap_wr2;
		logic merge;
		logic root_rd;
		logic root_cap;
		logic leaf_cap;
		logic leaf_mod;
		logic walk_int;
		logic pop_rd;
		logic pop_cap;
		logic out_scan;
		logic out_load;
		logic done;
	} hcb_cmd_t;

	typedef struct packed {
		logic cnt_one;
		logic scan_end;
		logic phase;
		logic m_two;
		logic is_leaf;
		logic len_full;
		logic sp_zero;
		logic sym_big;
		logic has_cur;
		logic out_last;
	} hcb_sts_t;
endpackage
`default_nettype wire

// File: hw/rtl/hcb_if.sv
// valid/ready channel interfaces for symbol beats and code beats
`default_nettype none
interface hcb_in_if import hcb_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [SYM_W-1:0]       symbol;
	logic [IN_WEIGHT_W-1:0] weight;
	logic                   final_item;
	modport source (output valid, symbol, weight, final_item, input ready);
	modport sink (input valid, symbol, weight, final_item, output ready);
endinterface

interface hcb_out_if import hcb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [SYM_W-1:0]  out_symbol;
	logic [CODE_W-1:0] code_bits;
	logic [LEN_W-1:0]  code_length;
	logic              overflow;
	logic              last_result;
	modport source (output valid, out_symbol, code_bits, code_length, overflow, last_result,
		input ready);
	modport sink (input valid, out_symbol, code_bits, code_length, overflow, last_result,
		output ready);
endinterface
`default_nettype wire

// File: hw/rtl/hcb_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module hcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// File: hw/rtl/hcb_ctrl.sv
// sequencer for load, tree merge, code walk and code output
`default_nettype none
module hcb_ctrl import hcb_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     in_final,
	input  wire logic     out_ready,
	input  wire hcb_sts_t sts,
	output hcb_cmd_t      cmd,
	output logic          in_ready,
	output logic          out_valid
);
	typedef enum logic [19:0] {
		IDLE   = 20'b00000000000000000001,
		START  = 20'b00000000000000000010,
		SC_RD  = 20'b00000000000000000100,
		SC_CMP = 20'b00000000000000001000,
		SW_RD  = 20'b00000000000000010000,
		SW_WR1 = 20'b00000000000000100000,
		SW_WR2 = 20'b00000000000001000000,
		MERGE  = 20'b00000000000010000000,
		R_RD   = 20'b00000000000100000000,
		R_CAP  = 20'b00000000001000000000,
		W_CHK  = 20'b00000000010000000000,
		W_LEAF = 20'b00000000100000000000,
		W_MOD  = 20'b00000001000000000000,
		W_INT  = 20'b00000010000000000000,
		P_RD   = 20'b00000100000000000000,
		P_CAP  = 20'b00001000000000000000,
		O_SCAN = 20'b00010000000000000000,
		O_LOAD = 20'b00100000000000000000,
		O_WAIT = 20'b01000000000000000000,
		DONE   = 20'b10000000000000000000
	} hcb_state_t;

	hcb_state_t st_q, st_nxt, pop_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= IDLE;
		end else begin
			st_q <= st_nxt;
		end
	end

	assign pop_nxt = sts.sp_zero ? O_SCAN : P_RD;

	always_comb begin
		st_nxt = st_q;
		case (st_q)
			IDLE:   if (in_valid && in_final) st_nxt = START;
			START:  st_nxt = sts.cnt_one ? R_RD : SC_RD;
			SC_RD:  st_nxt = SC_CMP;
			SC_CMP: st_nxt = sts.scan_end ? SW_RD : SC_RD;
			SW_RD:  st_nxt = SW_WR1;
			SW_WR1: st_nxt = SW_WR2;
			SW_WR2: st_nxt = sts.phase ? MERGE : SC_RD;
			MERGE:  st_nxt = sts.m_two ? R_RD : SC_RD;
			R_RD:   st_nxt = R_CAP;
			R_CAP:  st_nxt = W_CHK;
			W_CHK: begin
				if (sts.is_leaf) st_nxt = W_LEAF;
				else if (!sts.len_full) st_nxt = W_INT;
				else st_nxt = pop_nxt;
			end
			W_LEAF: st_nxt = W_MOD;
			W_MOD:  if (!sts.sym_big) st_nxt = pop_nxt;
			W_INT:  st_nxt = W_CHK;
			P_RD:   st_nxt = P_CAP;
			P_CAP:  st_nxt = W_CHK;
			O_SCAN: if (sts.has_cur) st_nxt = O_LOAD;
			O_LOAD: st_nxt = O_WAIT;
			O_WAIT: if (out_ready) st_nxt = sts.out_last ? DONE : O_SCAN;
			DONE:   st_nxt = IDLE;
			default: st_nxt = IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.load     = (st_q == IDLE) && in_valid;
		cmd.start    = (st_q == START);
		cmd.scan_rd  = (st_q == SC_RD);
		cmd.scan_cmp = (st_q == SC_CMP);
		cmd.tail_rd  = (st_q == SW_RD);
		cmd.swap_wr1 = (st_q == SW_WR1);
		cmd.swap_wr2 = (st_q == SW_WR2);
		cmd.merge    = (st_q == MERGE);
		cmd.root_rd  = (st_q == R_RD);
		cmd.root_cap = (st_q == R_CAP);
		cmd.leaf_cap = (st_q == W_LEAF);
		cmd.leaf_mod = (st_q == W_MOD);
		cmd.walk_int = (st_q == W_INT);
		cmd.pop_rd   = (st_q == P_RD);
		cmd.pop_cap  = (st_q == P_CAP);
		// symbol index moves on past empty slots and after a taken beat other than the last
		cmd.out_scan = ((st_q == O_SCAN) && !sts.has_cur) ||
			((st_q == O_WAIT) && out_ready && !sts.out_last);
		cmd.out_load = (st_q == O_LOAD);
		cmd.done     = (st_q == DONE);
	end

	assign in_ready  = (st_q == IDLE);
	assign out_valid = (st_q == O_WAIT);
endmodule
`default_nettype wire

// File: hw/rtl/hcb_dp.sv
// slot, tree, walk stack and code stores with their index registers
`default_nettype none
module hcb_dp import hcb_pkg::*; #(
	parameter int MAX_SYMBOLS  = 64,
	parameter int SYMBOL_SPACE = 128
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire hcb_cmd_t               cmd,
	output hcb_sts_t                    sts,
	input  wire logic [SYM_W-1:0]       in_symbol,
	input  wire logic [IN_WEIGHT_W-1:0] in_weight,
	output logic      [SYM_W-1:0]       out_symbol,
	output logic      [CODE_W-1:0]      code_bits,
	output logic      [LEN_W-1:0]       code_length,
	output logic                        overflow,
	output logic                        last_result
);
	localparam int CW       = $clog2(MAX_SYMBOLS + 1);
	localparam int SW       = $clog2(MAX_SYMBOLS);
	localparam int NW       = $clog2(2 * MAX_SYMBOLS);
	localparam int YW       = $clog2(SYMBOL_SPACE);
	localparam int SLOT_DW  = NW + WEIGHT_W;
	localparam int STK_DW   = NW + CODE_W + LEN_W;
	localparam int CODE_DW  = CODE_W + LEN_W;
	localparam int NODE_D   = 2 * MAX_SYMBOLS - 1;
	localparam int STK_D    = 2 * MAX_SYMBOLS;

	// control state
	logic [CW-1:0]           cnt_q, m_q;
	logic                    drop_q, phase_q;
	logic [SYMBOL_SPACE-1:0] has_q;
	// working registers
	logic [NW-1:0]      next_q, sp_q, e_node_q;
	logic [SW-1:0]      j_q, best_q;
	logic [SLOT_DW-1:0] bestv_q, a_q, b_q;
	logic [CODE_W-1:0]  e_code_q;
	logic [LEN_W-1:0]   e_len_q;
	logic [SYM_W-1:0]   sym_q;
	logic [YW-1:0]      s_q, max_q;

	logic [CW-1:0]      scan_lim, m_m2;
	logic               sym_big;

	logic               slot_we;
	logic [SW-1:0]      slot_waddr, slot_raddr;
	logic [SLOT_DW-1:0] slot_wdata, slot_rd;
	logic [SYM_W-1:0]   leaf_rd;
	logic [2*NW-1:0]    child_rd;
	logic [STK_DW-1:0]  stk_wdata, stk_rd;
	logic [CODE_DW-1:0] code_rd;
	logic               load_keep;

	assign scan_lim  = phase_q ? (m_q - CW'(2)) : (m_q - CW'(1));
	assign m_m2      = m_q - CW'(2);
	assign sym_big   = {1'b0, sym_q} >= (SYM_W + 1)'(SYMBOL_SPACE);
	assign load_keep = cnt_q < CW'(MAX_SYMBOLS);

	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = cnt_q[SW-1:0];
		slot_wdata = {NW'(cnt_q), WEIGHT_W'(in_weight)};
		if (cmd.load && load_keep) begin
			slot_we = 1'b1;
		end else if (cmd.swap_wr1) begin
			slot_we    = 1'b1;
			slot_waddr = best_q;
			slot_wdata = slot_rd;
		end else if (cmd.swap_wr2) begin
			slot_we    = 1'b1;
			slot_waddr = scan_lim[SW-1:0];
			slot_wdata = bestv_q;
		end else if (cmd.merge) begin
			slot_we    = 1'b1;
			slot_waddr = m_m2[SW-1:0];
			slot_wdata = {next_q, a_q[WEIGHT_W-1:0] + b_q[WEIGHT_W-1:0]};
		end
	end

	always_comb begin
		slot_raddr = '0;
		if (cmd.scan_rd) slot_raddr = j_q;
		else if (cmd.tail_rd) slot_raddr = scan_lim[SW-1:0];
		else if (cmd.root_rd) slot_raddr = '0;
	end

	assign stk_wdata = {child_rd[NW-1:0], e_code_q[CODE_W-2:0], 1'b1, e_len_q + LEN_W'(1)};

	hcb_ram #(.WIDTH(SLOT_DW), .DEPTH(MAX_SYMBOLS)) u_slot (
		.clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
		.raddr(slot_raddr), .rdata(slot_rd)
	);

	hcb_ram #(.WIDTH(SYM_W), .DEPTH(MAX_SYMBOLS)) u_leaf (
		.clk(clk), .we(cmd.load && load_keep), .waddr(cnt_q[SW-1:0]), .wdata(in_symbol),
		.raddr(e_node_q[SW-1:0]), .rdata(leaf_rd)
	);

	// left child in the upper half, right child below
	hcb_ram #(.WIDTH(2 * NW), .DEPTH(NODE_D)) u_child (
		.clk(clk), .we(cmd.merge), .waddr(next_q),
		.wdata({a_q[SLOT_DW-1:WEIGHT_W], b_q[SLOT_DW-1:WEIGHT_W]}),
		.raddr(e_node_q), .rdata(child_rd)
	);

	hcb_ram #(.WIDTH(STK_DW), .DEPTH(STK_D)) u_stack (
		.clk(clk), .we(cmd.walk_int), .waddr(sp_q), .wdata(stk_wdata),
		.raddr(sp_q - NW'(1)), .rdata(stk_rd)
	);

	hcb_ram #(.WIDTH(CODE_DW), .DEPTH(SYMBOL_SPACE)) u_code (
		.clk(clk), .we(cmd.leaf_mod && !sym_big), .waddr(sym_q[YW-1:0]),
		.wdata({e_code_q, e_len_q}), .raddr(s_q), .rdata(code_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			drop_q  <= 1'b0;
			has_q   <= '0;
			m_q     <= '0;
			phase_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (load_keep) cnt_q <= cnt_q + CW'(1);
				else drop_q <= 1'b1;
			end
			if (cmd.start) begin
				has_q   <= '0;
				m_q     <= cnt_q;
				phase_q <= 1'b0;
			end
			if (cmd.swap_wr2) phase_q <= 1'b1;
			if (cmd.merge) begin
				m_q     <= m_q - CW'(1);
				phase_q <= 1'b0;
			end
			if (cmd.leaf_mod && !sym_big) has_q[sym_q[YW-1:0]] <= 1'b1;
			if (cmd.done) begin
				cnt_q  <= '0;
				drop_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			next_q <= NW'(cnt_q);
			j_q    <= '0;
			s_q    <= '0;
			max_q  <= '0;
		end
		if (cmd.scan_cmp) begin
			// first minimum: only a strictly smaller weight takes over
			if (j_q == '0 || bestv_q[WEIGHT_W-1:0] > slot_rd[WEIGHT_W-1:0]) begin
				best_q  <= j_q;
				bestv_q <= slot_rd;
			end
			if (CW'(j_q) != scan_lim) j_q <= j_q + SW'(1);
		end
		if (cmd.swap_wr2) begin
			j_q <= '0;
			if (phase_q) a_q <= bestv_q;
			else b_q <= bestv_q;
		end
		if (cmd.merge) begin
			next_q <= next_q + NW'(1);
			j_q    <= '0;
		end
		if (cmd.root_cap) begin
			e_node_q <= slot_rd[SLOT_DW-1:WEIGHT_W];
			e_code_q <= '0;
			e_len_q  <= '0;
			sp_q     <= '0;
		end
		if (cmd.leaf_cap) sym_q <= leaf_rd;
		if (cmd.leaf_mod) begin
			if (sym_big) begin
				sym_q <= sym_q - SYM_W'(SYMBOL_SPACE);
			end else if (sym_q[YW-1:0] > max_q) begin
				max_q <= sym_q[YW-1:0];
			end
		end
		if (cmd.walk_int) begin
			sp_q     <= sp_q + NW'(1);
			e_node_q <= child_rd[2*NW-1:NW];
			e_code_q <= {e_code_q[CODE_W-2:0], 1'b0};
			e_len_q  <= e_len_q + LEN_W'(1);
		end
		if (cmd.pop_rd) sp_q <= sp_q - NW'(1);
		if (cmd.pop_cap) begin
			e_node_q <= stk_rd[STK_DW-1:CODE_DW];
			e_code_q <= stk_rd[CODE_DW-1:LEN_W];
			e_len_q  <= stk_rd[LEN_W-1:0];
		end
		if (cmd.out_scan) s_q <= s_q + YW'(1);
		if (cmd.out_load) begin
			out_symbol  <= SYM_W'(s_q);
			code_bits   <= code_rd[CODE_DW-1:LEN_W];
			code_length <= code_rd[LEN_W-1:0];
			overflow    <= drop_q;
			last_result <= (s_q == max_q);
		end
	end

	always_comb begin
		sts          = '0;
		sts.cnt_one  = (cnt_q == CW'(1));
		sts.scan_end = (CW'(j_q) == scan_lim);
		sts.phase    = phase_q;
		sts.m_two    = (m_q == CW'(2));
		sts.is_leaf  = (e_node_q < NW'(cnt_q));
		sts.len_full = (e_len_q == LEN_MAX);
		sts.sp_zero  = (sp_q == '0);
		sts.sym_big  = sym_big;
		sts.has_cur  = has_q[s_q];
		sts.out_last = (s_q == max_q);
	end

`ifndef SYNTH
	a_swap_idx: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.swap_wr1 |-> CW'(best_q) <= scan_lim)
		else $error("minimum index beyond scanned slots");
	a_merge_m: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.merge |-> (m_q >= CW'(2)) && (m_q <= CW'(MAX_SYMBOLS)))
		else $error("merge with fewer than two live slots");
	a_pop_sp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_rd |-> sp_q != '0)
		else $error("walk stack underflow");
`endif
endmodule
`default_nettype wire

// File: hw/rtl/huffman_code_builder_unit.sv
// huffman code builder top level: controller plus datapath
//
//  channel  dir  payload                                                  beat when
//  in_ch    in   symbol, weight, final_item                               valid && ready
//  out_ch   out  out_symbol, code_bits, code_length, overflow, last_result valid && ready
//
// items load at one per cycle; a final item starts the build and the input stays
// closed until the last code beat of that set is taken.
// tree build: each merge scans the live slots for the least weight, a read then a compare
// per slot set by the registered read of the slot ram, swaps it to the tail, repeats for
// the next and writes the merged node. code walk: check then push per inner node, check,
// read and write per leaf, read then capture per stack pop; output: the index steps up
// to the largest coded symbol value; stalls hold the sequencer in its wait state.
// reset clears the sequencer, load count, overflow flag and coded-symbol bits.
`default_nettype none
module huffman_code_builder_unit import hcb_pkg::*; #(
	parameter int MAX_SYMBOLS  = 64,
	parameter int SYMBOL_SPACE = 128
) (
	input wire logic  clk,
	input wire logic  arst_n,
	hcb_in_if.sink    in_ch,
	hcb_out_if.source out_ch
);
	hcb_cmd_t cmd;
	hcb_sts_t sts;

	hcb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_final(in_ch.final_item), .out_ready(out_ch.ready),
		.sts(sts), .cmd(cmd), .in_ready(in_ch.ready), .out_valid(out_ch.valid)
	);

	hcb_dp #(.MAX_SYMBOLS(MAX_SYMBOLS), .SYMBOL_SPACE(SYMBOL_SPACE)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_symbol(in_ch.symbol), .in_weight(in_ch.weight),
		.out_symbol(out_ch.out_symbol), .code_bits(out_ch.code_bits),
		.code_length(out_ch.code_length), .overflow(out_ch.overflow),
		.last_result(out_ch.last_result)
	);
endmodule
`default_nettype wire
